>>> src/sbpq_pkg.sv
// shared types, constants and helpers of the segmented block pool queues
`default_nettype none
package sbpq_pkg;

   localparam int MAX_BLOCKS  = 64;
   localparam int NUM_STREAMS = 2;

   localparam int IDX_W     = $clog2(MAX_BLOCKS);
   localparam int CNT_W     = $clog2(MAX_BLOCKS + 1);
   localparam int STRM_W    = 1;
   localparam int NSLOT     = 1 << STRM_W;
   localparam int CMD_W     = 2;
   localparam int STAT_W    = 3;
   localparam int LEN_W     = 22;
   localparam int UNIT_W    = 17;
   localparam int CFG_CNT_W = 7;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DAT_W = 17;
   localparam int MEM_DEPTH = NSLOT * MAX_BLOCKS;
   localparam int MEM_AW    = STRM_W + IDX_W;
   localparam int OFF_W     = IDX_W + UNIT_W;
   localparam int ROOM_W    = CNT_W + UNIT_W;
   localparam int CMPW      = ROOM_W + LEN_W;
   localparam int JOB_Q_DEPTH = 2;
   localparam int RSP_Q_DEPTH = 4;

   localparam logic [UNIT_W-1:0]    UNIT_MAX    = 17'h10000;
   localparam logic [UNIT_W-1:0]    UNIT_RESET  = 17'd4096;
   localparam logic [CFG_CNT_W-1:0] COUNT_RESET = 7'd64;

   localparam logic [CMD_W-1:0] CMD_PUT     = 2'd0;
   localparam logic [CMD_W-1:0] CMD_GET     = 2'd1;
   localparam logic [CMD_W-1:0] CMD_RELEASE = 2'd2;
   localparam logic [CMD_W-1:0] CMD_NONE    = 2'd3;

   localparam logic [STAT_W-1:0] STAT_OK        = 3'd0;
   localparam logic [STAT_W-1:0] STAT_NO_ROOM   = 3'd1;
   localparam logic [STAT_W-1:0] STAT_NOTHING   = 3'd2;
   localparam logic [STAT_W-1:0] STAT_MISMATCH  = 3'd3;
   localparam logic [STAT_W-1:0] STAT_OFF       = 3'd4;
   localparam logic [STAT_W-1:0] STAT_REL_EMPTY = 3'd5;

   localparam logic [CSR_IDX_W-1:0] REG_MAIN_ENABLE = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_SUB_ENABLE  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_MAIN_UNIT   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_SUB_UNIT    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_MAIN_COUNT  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_SUB_COUNT   = 3'd5;

   typedef enum logic [1:0] {OP_PUT, OP_GET, OP_REL, OP_OFF} op_type;

   typedef struct packed {
      logic [CMD_W-1:0]  command;
      logic [STRM_W-1:0] stream;
      logic [LEN_W-1:0]  data_length;
      logic [LEN_W-1:0]  block_offset;
   } req_type;

   typedef struct packed {
      logic [STAT_W-1:0] status;
      logic [IDX_W-1:0]  block_index;
      logic [LEN_W-1:0]  byte_offset;
      logic [UNIT_W-1:0] fill_length;
      logic              last;
   } rsp_type;

   typedef struct packed {
      op_type            op;
      logic [STRM_W-1:0] stream;
      logic [LEN_W-1:0]  data_length;
      logic [LEN_W-1:0]  block_offset;
      logic [UNIT_W-1:0] unit;
   } job_type;

   typedef struct packed {
      logic              valid;
      logic [STRM_W-1:0] stream;
      logic [CNT_W-1:0]  count;
   } pool_init_type;

   function automatic logic [IDX_W-1:0] ring_step(logic [IDX_W-1:0] head);
      return (head == IDX_W'(MAX_BLOCKS - 1)) ? '0 : head + 1'b1;
   endfunction

   function automatic logic [IDX_W-1:0] ring_pos(logic [IDX_W-1:0] head,
                                                 logic [CNT_W-1:0] count);
      logic [CNT_W:0] sum;
      sum = (CNT_W+1)'(head) + (CNT_W+1)'(count);
      if (sum >= (CNT_W+1)'(MAX_BLOCKS)) begin
         sum = sum - (CNT_W+1)'(MAX_BLOCKS);
      end
      return sum[IDX_W-1:0];
   endfunction

   function automatic logic [CNT_W-1:0] sat_count(logic [CFG_CNT_W-1:0] c);
      if (int'(c) > MAX_BLOCKS) begin
         return CNT_W'(MAX_BLOCKS);
      end
      return CNT_W'(c);
   endfunction

endpackage
`default_nettype wire

>>> src/sbpq_ram.sv
// generic single write port ram with registered read
`default_nettype none
module sbpq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule
`default_nettype wire

>>> src/sbpq_front.sv
// front end: settings registers, item classification and job queue
`default_nettype none
module sbpq_front (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [sbpq_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [sbpq_pkg::CSR_DAT_W-1:0]   csr_data,
   input  logic                             req_push,
   output logic                             req_full,
   input  sbpq_pkg::req_type                req_data,
   output logic                             job_valid,
   input  logic                             job_pop,
   output sbpq_pkg::job_type                job,
   output sbpq_pkg::pool_init_type          pool_init
);
   import sbpq_pkg::*;

   localparam int QPW = $clog2(JOB_Q_DEPTH);
   localparam int QCW = $clog2(JOB_Q_DEPTH + 1);

   logic                 enable_ff [NSLOT];
   logic [UNIT_W-1:0]    unit_ff   [NSLOT];
   logic [CFG_CNT_W-1:0] count_ff  [NSLOT];
   pool_init_type        init_ff;

   job_type          q_ff [JOB_Q_DEPTH];
   logic [QPW-1:0]   wr_ptr_ff;
   logic [QPW-1:0]   rd_ptr_ff;
   logic [QCW-1:0]   q_cnt_ff;

   logic                 wr_known;
   logic [STRM_W-1:0]    wr_stream;
   logic [CFG_CNT_W-1:0] new_count;
   logic [STRM_W-1:0]    s;
   logic [UNIT_W-1:0]    unit_sat;
   logic                 off;
   logic                 enq;
   logic                 deq;
   job_type              new_job;

   assign csr_ready = 1'b1;
   assign wr_known  = csr_valid && (csr_index <= REG_SUB_COUNT);
   assign wr_stream = STRM_W'(csr_index[0]);
   // block count the re-initialised pool starts with
   assign new_count = (csr_index == REG_MAIN_COUNT || csr_index == REG_SUB_COUNT)
                      ? csr_data[CFG_CNT_W-1:0] : count_ff[wr_stream];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NSLOT; i++) begin
            enable_ff[i] <= 1'b0;
            unit_ff[i]   <= UNIT_RESET;
            count_ff[i]  <= COUNT_RESET;
         end
         init_ff <= '0;
      end else begin
         init_ff.valid  <= wr_known;
         init_ff.stream <= wr_stream;
         init_ff.count  <= sat_count(new_count);
         if (csr_valid) begin
            unique case (csr_index)
               REG_MAIN_ENABLE, REG_SUB_ENABLE: begin
                  enable_ff[wr_stream] <= csr_data[0];
               end
               REG_MAIN_UNIT, REG_SUB_UNIT: begin
                  unit_ff[wr_stream] <= csr_data;
               end
               REG_MAIN_COUNT, REG_SUB_COUNT: begin
                  count_ff[wr_stream] <= csr_data[CFG_CNT_W-1:0];
               end
               default: begin
               end
            endcase
         end
      end
   end

   assign pool_init = init_ff;

   // classification
   assign s        = req_data.stream;
   assign unit_sat = (unit_ff[s] > UNIT_MAX) ? UNIT_MAX : unit_ff[s];
   assign off      = (int'(s) >= NUM_STREAMS) || !enable_ff[s] || (unit_sat == '0);

   always_comb begin
      new_job.stream       = s;
      new_job.data_length  = req_data.data_length;
      new_job.block_offset = req_data.block_offset;
      new_job.unit         = unit_sat;
      if (off) begin
         new_job.op = OP_OFF;
      end else begin
         unique case (req_data.command)
            CMD_PUT: new_job.op = OP_PUT;
            CMD_GET: new_job.op = OP_GET;
            default: new_job.op = OP_REL;
         endcase
      end
   end

   assign req_full  = (q_cnt_ff == QCW'(JOB_Q_DEPTH));
   assign enq       = req_push && !req_full && (req_data.command != CMD_NONE);
   assign job_valid = (q_cnt_ff != '0);
   assign deq       = job_pop && job_valid;
   assign job       = q_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (enq) begin
         q_ff[wr_ptr_ff] <= new_job;
      end
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         q_cnt_ff  <= '0;
      end else begin
         if (enq) begin
            wr_ptr_ff <= (wr_ptr_ff == QPW'(JOB_Q_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (deq) begin
            rd_ptr_ff <= (rd_ptr_ff == QPW'(JOB_Q_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (enq && !deq) begin
            q_cnt_ff <= q_cnt_ff + 1'b1;
         end else if (deq && !enq) begin
            q_cnt_ff <= q_cnt_ff - 1'b1;
         end
      end
   end
endmodule
`default_nettype wire

>>> src/sbpq_back.sv
// back end: pool sequencer over the ring and fill memories
`default_nettype none
module sbpq_back (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    job_valid,
   output logic                    job_pop,
   input  sbpq_pkg::job_type       job,
   input  sbpq_pkg::pool_init_type pool_init,
   output logic                    res_push,
   input  logic                    res_full,
   output sbpq_pkg::rsp_type       res
);
   import sbpq_pkg::*;

   typedef enum logic [8:0] {
      ST_IDLE   = 9'b000000001,
      ST_DECODE = 9'b000000010,
      ST_ROOM   = 9'b000000100,
      ST_ALLOC  = 9'b000001000,
      ST_TAKE   = 9'b000010000,
      ST_OFFSET = 9'b000100000,
      ST_LOOKUP = 9'b001000000,
      ST_FILL   = 9'b010000000,
      ST_EMIT   = 9'b100000000
   } state_type;

   state_type          state_ff;
   job_type            job_ff;
   logic [IDX_W-1:0]   blk_ff;
   logic [LEN_W-1:0]   remain_ff;
   logic [ROOM_W-1:0]  room_ff;
   rsp_type            res_ff;

   logic [IDX_W-1:0]      free_head_ff   [NSLOT];
   logic [CNT_W-1:0]      free_count_ff  [NSLOT];
   logic [IDX_W-1:0]      filled_head_ff [NSLOT];
   logic [CNT_W-1:0]      filled_count_ff[NSLOT];
   logic [IDX_W-1:0]      rel_head_ff    [NSLOT];
   logic [CNT_W-1:0]      rel_count_ff   [NSLOT];
   logic [MAX_BLOCKS-1:0] free_valid_ff  [NSLOT];

   logic [STRM_W-1:0] s;
   logic [IDX_W-1:0]  free_rd, filled_rd, rel_rd;
   logic [UNIT_W-1:0] fill_rd;
   logic [IDX_W-1:0]  blk_take, blk_look, free_tail;
   logic [UNIT_W-1:0] piece;
   logic [OFF_W-1:0]  off_full;
   logic [LEN_W-1:0]  off_cut;
   logic              match;
   logic              no_room;

   logic               free_wr, free_rd_en, filled_wr, filled_rd_en;
   logic               rel_wr, rel_rd_en, fill_wr, fill_rd_en;
   logic [MEM_AW-1:0]  free_wa, free_ra, filled_wa, filled_ra;
   logic [MEM_AW-1:0]  rel_wa, rel_ra, fill_wa, fill_ra;

   // single closing result with no block named
   function automatic rsp_type closing_rsp(logic [STAT_W-1:0] st);
      rsp_type r;
      r        = '0;
      r.status = st;
      r.last   = 1'b1;
      return r;
   endfunction

   assign s         = job_ff.stream;
   assign free_tail = ring_pos(free_head_ff[s], free_count_ff[s]);
   assign blk_take  = free_valid_ff[s][free_head_ff[s]] ? free_rd : free_head_ff[s];
   assign blk_look  = (job_ff.op == OP_GET) ? filled_rd : rel_rd;
   assign piece     = ((LEN_W+1)'(remain_ff) > (LEN_W+1)'(job_ff.unit))
                      ? job_ff.unit : UNIT_W'(remain_ff);
   assign off_full  = OFF_W'(blk_ff) * OFF_W'(job_ff.unit);
   assign off_cut   = LEN_W'(off_full);
   assign match     = (off_cut == job_ff.block_offset);
   assign no_room   = CMPW'(job_ff.data_length) >= CMPW'(room_ff);

   // memory controls follow the sequencer state
   always_comb begin
      free_rd_en   = (state_ff == ST_ALLOC);
      free_ra      = {s, free_head_ff[s]};
      free_wr      = (state_ff == ST_FILL) && (job_ff.op == OP_REL) && match;
      free_wa      = {s, free_tail};
      filled_rd_en = (state_ff == ST_DECODE) && (job_ff.op == OP_GET);
      filled_ra    = {s, filled_head_ff[s]};
      filled_wr    = (state_ff == ST_TAKE);
      filled_wa    = {s, ring_pos(filled_head_ff[s], filled_count_ff[s])};
      rel_rd_en    = (state_ff == ST_DECODE) && (job_ff.op == OP_REL);
      rel_ra       = {s, rel_head_ff[s]};
      rel_wr       = (state_ff == ST_LOOKUP) && (job_ff.op == OP_GET);
      rel_wa       = {s, ring_pos(rel_head_ff[s], rel_count_ff[s])};
      fill_wr      = (state_ff == ST_TAKE);
      fill_wa      = {s, blk_take};
      fill_rd_en   = (state_ff == ST_LOOKUP);
      fill_ra      = {s, blk_look};
   end

   sbpq_ram #(.WIDTH(IDX_W), .DEPTH(MEM_DEPTH)) u_free_ring (
      .clock(clock), .wr_en(free_wr), .wr_addr(free_wa), .wr_data(blk_ff),
      .rd_en(free_rd_en), .rd_addr(free_ra), .rd_data(free_rd));

   sbpq_ram #(.WIDTH(IDX_W), .DEPTH(MEM_DEPTH)) u_filled_ring (
      .clock(clock), .wr_en(filled_wr), .wr_addr(filled_wa), .wr_data(blk_take),
      .rd_en(filled_rd_en), .rd_addr(filled_ra), .rd_data(filled_rd));

   sbpq_ram #(.WIDTH(IDX_W), .DEPTH(MEM_DEPTH)) u_release_ring (
      .clock(clock), .wr_en(rel_wr), .wr_addr(rel_wa), .wr_data(blk_look),
      .rd_en(rel_rd_en), .rd_addr(rel_ra), .rd_data(rel_rd));

   sbpq_ram #(.WIDTH(UNIT_W), .DEPTH(MEM_DEPTH)) u_block_fill (
      .clock(clock), .wr_en(fill_wr), .wr_addr(fill_wa), .wr_data(piece),
      .rd_en(fill_rd_en), .rd_addr(fill_ra), .rd_data(fill_rd));

   assign job_pop  = (state_ff == ST_IDLE) && job_valid;
   assign res_push = (state_ff == ST_EMIT) && !res_full;
   assign res      = res_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         for (int i = 0; i < NSLOT; i++) begin
            free_head_ff[i]    <= '0;
            free_count_ff[i]   <= sat_count(COUNT_RESET);
            filled_head_ff[i]  <= '0;
            filled_count_ff[i] <= '0;
            rel_head_ff[i]     <= '0;
            rel_count_ff[i]    <= '0;
            free_valid_ff[i]   <= '0;
         end
      end else if (pool_init.valid) begin
         // settings changes must come only while idle; this block does not enforce it
         free_head_ff[pool_init.stream]    <= '0;
         free_count_ff[pool_init.stream]   <= pool_init.count;
         filled_head_ff[pool_init.stream]  <= '0;
         filled_count_ff[pool_init.stream] <= '0;
         rel_head_ff[pool_init.stream]     <= '0;
         rel_count_ff[pool_init.stream]    <= '0;
         free_valid_ff[pool_init.stream]   <= '0;
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               if (job_valid) begin
                  job_ff   <= job;
                  state_ff <= ST_DECODE;
               end
            end
            ST_DECODE: begin
               unique case (job_ff.op)
                  OP_PUT: begin
                     res_ff   <= closing_rsp(STAT_OK);
                     room_ff  <= ROOM_W'(free_count_ff[s]) * ROOM_W'(job_ff.unit);
                     state_ff <= ST_ROOM;
                  end
                  OP_GET: begin
                     if (filled_count_ff[s] == '0) begin
                        res_ff   <= closing_rsp(STAT_NOTHING);
                        state_ff <= ST_EMIT;
                     end else begin
                        res_ff   <= closing_rsp(STAT_OK);
                        state_ff <= ST_LOOKUP;
                     end
                  end
                  OP_REL: begin
                     if (rel_count_ff[s] == '0) begin
                        res_ff   <= closing_rsp(STAT_REL_EMPTY);
                        state_ff <= ST_EMIT;
                     end else begin
                        res_ff   <= closing_rsp(STAT_OK);
                        state_ff <= ST_LOOKUP;
                     end
                  end
                  default: begin
                     res_ff   <= closing_rsp(STAT_OFF);
                     state_ff <= ST_EMIT;
                  end
               endcase
            end
            ST_ROOM: begin
               // room when length is below free blocks times unit size
               if (no_room) begin
                  res_ff.status <= STAT_NO_ROOM;
                  state_ff      <= ST_EMIT;
               end else if (job_ff.data_length == '0) begin
                  state_ff <= ST_EMIT;
               end else begin
                  remain_ff <= job_ff.data_length;
                  state_ff  <= ST_ALLOC;
               end
            end
            ST_ALLOC: begin
               state_ff <= ST_TAKE;
            end
            ST_TAKE: begin
               blk_ff                <= blk_take;
               remain_ff             <= remain_ff - LEN_W'(piece);
               free_head_ff[s]       <= ring_step(free_head_ff[s]);
               free_count_ff[s]      <= free_count_ff[s] - 1'b1;
               filled_count_ff[s]    <= filled_count_ff[s] + 1'b1;
               res_ff.status         <= STAT_OK;
               res_ff.block_index    <= blk_take;
               res_ff.fill_length    <= piece;
               res_ff.last           <= (remain_ff == LEN_W'(piece));
               state_ff              <= ST_OFFSET;
            end
            ST_OFFSET: begin
               res_ff.byte_offset <= off_cut;
               state_ff           <= ST_EMIT;
            end
            ST_LOOKUP: begin
               blk_ff <= blk_look;
               if (job_ff.op == OP_GET) begin
                  filled_head_ff[s]  <= ring_step(filled_head_ff[s]);
                  filled_count_ff[s] <= filled_count_ff[s] - 1'b1;
                  rel_count_ff[s]    <= rel_count_ff[s] + 1'b1;
               end
               state_ff <= ST_FILL;
            end
            ST_FILL: begin
               res_ff.block_index <= blk_ff;
               res_ff.byte_offset <= off_cut;
               res_ff.fill_length <= fill_rd;
               // wrong offset leaves the head queued
               res_ff.status      <= (job_ff.op == OP_REL && !match) ? STAT_MISMATCH
                                                                     : STAT_OK;
               if (job_ff.op == OP_REL && match) begin
                  rel_head_ff[s]              <= ring_step(rel_head_ff[s]);
                  rel_count_ff[s]             <= rel_count_ff[s] - 1'b1;
                  free_count_ff[s]            <= free_count_ff[s] + 1'b1;
                  free_valid_ff[s][free_tail] <= 1'b1;
               end
               state_ff <= ST_EMIT;
            end
            ST_EMIT: begin
               if (!res_full) begin
                  state_ff <= res_ff.last ? ST_IDLE : ST_ALLOC;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end
endmodule
`default_nettype wire

>>> src/sbpq_rsp_fifo.sv
// result item queue between the sequencer and the result ports
`default_nettype none
module sbpq_rsp_fifo (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   output logic              full,
   input  sbpq_pkg::rsp_type push_data,
   output logic              empty,
   input  logic              pop,
   output sbpq_pkg::rsp_type pop_data
);
   import sbpq_pkg::*;

   localparam int PW = $clog2(RSP_Q_DEPTH);
   localparam int CW = $clog2(RSP_Q_DEPTH + 1);

   rsp_type       q_ff [RSP_Q_DEPTH];
   logic [PW-1:0] wr_ptr_ff;
   logic [PW-1:0] rd_ptr_ff;
   logic [CW-1:0] cnt_ff;
   logic          wr, rd;

   assign full     = (cnt_ff == CW'(RSP_Q_DEPTH));
   assign empty    = (cnt_ff == '0);
   assign wr       = push && !full;
   assign rd       = pop && !empty;
   assign pop_data = q_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (wr) begin
         q_ff[wr_ptr_ff] <= push_data;
      end
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         if (wr) begin
            wr_ptr_ff <= (wr_ptr_ff == PW'(RSP_Q_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (rd) begin
            rd_ptr_ff <= (rd_ptr_ff == PW'(RSP_Q_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (wr && !rd) begin
            cnt_ff <= cnt_ff + 1'b1;
         end else if (rd && !wr) begin
            cnt_ff <= cnt_ff - 1'b1;
         end
      end
   end
endmodule
`default_nettype wire

>>> src/segmented_block_pool_queues.sv
// top level of the segmented block pool queues
// Descriptor manager for two stream pools (main and sub) of fixed-size
// blocks, each block sitting in a free, filled or awaiting-release ring.
// Items come in through a queue-style port (push/full) and results leave
// through another (empty/pop); a put gives one result item per block taken
// (one if refused or of zero length), every other command except none gives
// exactly one. The front end classifies each item against the settings and
// parks it in a two-entry job queue; the back end sequencer works one job at
// a time against registered-read ring memories. Steps: a put goes through
// set-up and room check, then per block free ring read, block take,
// offset multiply and result write; a refused or zero-length put goes
// from the room check to its result write; get and release go through
// ring lookup, fill read and result write, a release with a wrong offset
// included; nothing-filled, release-empty and stream-off items go from
// set-up to the result write. A result reaches the ports the cycle after
// it is written. No clearing pass is needed after reset: free ring slots
// not yet written read as their own position through per-slot valid
// flags. A settings write re-initialises the pool of its stream via a
// registered strobe and must only come while idle.
`default_nettype none
module segmented_block_pool_queues (
   input  logic                           clock,
   input  logic                           reset,
   // item input
   input  logic                           req_push,
   output logic                           req_full,
   input  sbpq_pkg::req_type              req_data,
   // result output
   output logic                           rsp_empty,
   input  logic                           rsp_pop,
   output sbpq_pkg::rsp_type              rsp_data,
   // settings writes
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [sbpq_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [sbpq_pkg::CSR_DAT_W-1:0] csr_data
);
   import sbpq_pkg::*;

   logic          job_valid;
   logic          job_pop;
   job_type       job;
   pool_init_type pool_init;
   logic          res_push;
   logic          res_full;
   rsp_type       res;

   // classification and job queue
   sbpq_front u_front (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_data  (req_data),
      .job_valid (job_valid),
      .job_pop   (job_pop),
      .job       (job),
      .pool_init (pool_init)
   );

   // ring bookkeeping and result generation
   sbpq_back u_back (
      .clock     (clock),
      .reset     (reset),
      .job_valid (job_valid),
      .job_pop   (job_pop),
      .job       (job),
      .pool_init (pool_init),
      .res_push  (res_push),
      .res_full  (res_full),
      .res       (res)
   );

   // result items wait here so the sequencer can move on
   sbpq_rsp_fifo u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (res_push),
      .full      (res_full),
      .push_data (res),
      .empty     (rsp_empty),
      .pop       (rsp_pop),
      .pop_data  (rsp_data)
   );
endmodule
`default_nettype wire

>>> src/sbpq_checker.sv
// port-level checks of the segmented block pool queues and their binding
`default_nettype none
module sbpq_checker (
   input logic              clock,
   input logic              reset,
   input logic              rsp_empty,
   input logic              rsp_pop,
   input sbpq_pkg::rsp_type rsp_data
);
   import sbpq_pkg::*;

   // error items always close their item
   a_err_last: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_data.status != STAT_OK) |-> rsp_data.last)
      else $error("error result without last");

   // errors that name no block carry zero fields
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && (rsp_data.status == STAT_NO_ROOM || rsp_data.status == STAT_NOTHING ||
                      rsp_data.status == STAT_OFF || rsp_data.status == STAT_REL_EMPTY))
      |-> (rsp_data.block_index == '0 && rsp_data.byte_offset == '0 &&
           rsp_data.fill_length == '0))
      else $error("error result with block fields");

   // block fill never exceeds the largest unit and the status is a known code
   a_fill_max: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> (rsp_data.fill_length <= UNIT_MAX && rsp_data.status <= STAT_REL_EMPTY))
      else $error("result out of range");

   // a waiting result holds until taken
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=> (!rsp_empty && $stable(rsp_data)))
      else $error("waiting result changed");
endmodule

bind segmented_block_pool_queues sbpq_checker u_checker (.*);
`default_nettype wire
